### sv/rftn_pkg.sv
// ----------------------------------------------------------------------------
// rftn_pkg - shared types and constants for the RGBA filter tap normalizer
// Field widths, accumulator widths, divider step count and the command
// bundle that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rftn_pkg;

  localparam int CH_W    = 8;   // one color or alpha byte
  localparam int WT_W    = 16;  // signed Q14 tap weight
  localparam int Q8_W    = 9;   // alpha scale factor, 0..256
  localparam int SUM_W   = 28;  // signed channel accumulator
  localparam int TOT_W   = 20;  // signed weight total
  localparam int PROD_W  = CH_W + 1 + WT_W;  // signed byte times weight
  localparam int NUM_W   = SUM_W + 1;        // rounded numerator
  localparam int DSH_W   = TOT_W + CH_W;     // divisor aligned to quotient bit 8
  localparam int Q_W     = CH_W + 1;         // quotient bits, top bit flags overflow
  localparam int DIV_STEPS = Q_W;
  localparam int KQ      = 14;
  localparam int N_LANES = 3;

  // Controller to datapath commands.
  typedef struct packed {
    logic cfg_we;    // write the mode register
    logic load;      // capture an accepted tap into the weighting stage
    logic acc;       // add the weighting stage into the sums
    logic setup;     // form divider operands, clear sums
    logic step;      // one restoring divide step on every lane
    logic finish;    // clamp quotients into the output register
  } cmd_t;

  // Straight-alpha scale factor (a*256+127)/255, which reduces to a + a[7].
  function automatic logic [Q8_W-1:0] alpha_q8(input logic [CH_W-1:0] a);
    return {1'b0, a} + {{(Q8_W-1){1'b0}}, a[CH_W-1]};
  endfunction

endpackage

`default_nettype wire

### sv/rftn_ctrl.sv
// ----------------------------------------------------------------------------
// rftn_ctrl - sequencer for the RGBA filter tap normalizer
// Gates the tap stream, counts taps per pixel, steps the divider and
// holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rftn_ctrl #(
  parameter int MAX_TAPS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic           in_tlast,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  output rftn_pkg::cmd_t      cmd
);
  import rftn_pkg::*;

  localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SETUP,
    ST_DIV,
    ST_FIN,
    ST_HOLD
  } state_t;

  state_t          state_r, state_nxt;
  logic [TW-1:0]   tap_cnt_r, tap_cnt_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic            s1_vld_r, s1_last_r;
  logic            accept;
  logic            last_eff;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_ACC) && !s1_last_r;
  assign out_tvalid = (state_r == ST_HOLD);
  assign accept     = in_tvalid && in_tready;
  // Force a close once the tap budget is used up.
  assign last_eff   = in_tlast || (tap_cnt_r == TW'(MAX_TAPS - 1));

  always_comb begin
    cmd        = '0;
    cmd.cfg_we = cfg_valid;
    cmd.load   = accept;
    cmd.acc    = s1_vld_r;
    cmd.setup  = (state_r == ST_SETUP);
    cmd.step   = (state_r == ST_DIV);
    cmd.finish = (state_r == ST_FIN);
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    tap_cnt_nxt = tap_cnt_r;
    if (accept) begin
      tap_cnt_nxt = last_eff ? '0 : tap_cnt_r + 1'b1;
    end
    case (state_r)
      ST_ACC: begin
        if (s1_last_r) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_DIV;
        step_nxt  = '0;
      end
      ST_DIV: begin
        if (step_r == SW'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_tready) begin
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_ACC;
      tap_cnt_r <= '0;
      step_r    <= '0;
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tap_cnt_r <= tap_cnt_nxt;
      step_r    <= step_nxt;
      s1_vld_r  <= accept;
      s1_last_r <= accept && last_eff;
    end
  end

endmodule

`default_nettype wire

### sv/rftn_dp.sv
// ----------------------------------------------------------------------------
// rftn_dp - datapath for the RGBA filter tap normalizer
// Alpha weighting, three channel accumulators, weight total, a three-lane
// restoring divider and the clamped output pixel register.
// ----------------------------------------------------------------------------
`default_nettype none

module rftn_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  rftn_pkg::cmd_t                      cmd,
  input  wire logic                           cfg_alpha_mode,
  input  wire logic [rftn_pkg::CH_W-1:0]      red_in,
  input  wire logic [rftn_pkg::CH_W-1:0]      green_in,
  input  wire logic [rftn_pkg::CH_W-1:0]      blue_in,
  input  wire logic [rftn_pkg::CH_W-1:0]      alpha_in,
  input  wire logic signed [rftn_pkg::WT_W-1:0] tap_weight,
  output logic [rftn_pkg::CH_W-1:0]           red_out,
  output logic [rftn_pkg::CH_W-1:0]           green_out,
  output logic [rftn_pkg::CH_W-1:0]           blue_out,
  output logic [rftn_pkg::CH_W-1:0]           alpha_out
);
  import rftn_pkg::*;

  localparam int WPROD_W = Q8_W + 1 + WT_W;

  logic                       mode_r;
  // weighting stage
  logic [CH_W-1:0]            s1_ch_r [N_LANES];
  logic signed [WT_W-1:0]     s1_fw_r;
  logic                       s1_mode_r;
  logic                       fin_mode_r;
  logic signed [WPROD_W-1:0]  wprod;
  logic signed [WT_W-1:0]     fw_nxt;
  // accumulators
  logic signed [SUM_W-1:0]    sum_r [N_LANES];
  logic signed [TOT_W-1:0]    tot_r;
  logic signed [PROD_W-1:0]   cprod [N_LANES];
  // divider
  logic [NUM_W-1:0]           rem_r [N_LANES];
  logic [Q_W-1:0]             quo_r [N_LANES];
  logic                       neg_r [N_LANES];
  logic [DSH_W-1:0]           dsh_r;
  logic                       empty_r;
  logic [CH_W-1:0]            alpha_r;
  // operand setup
  logic                       tot_neg;
  logic signed [TOT_W-1:0]    half;
  logic [TOT_W-1:0]           abs_d;
  logic signed [NUM_W-1:0]    num [N_LANES];
  logic [NUM_W-1:0]           abs_n [N_LANES];
  logic [DSH_W-1:0]           a255;
  logic [DSH_W-1:0]           a_rnd;
  logic [DSH_W-KQ-1:0]        a_hi;
  logic [CH_W-1:0]            alpha_sel;
  logic                       empty_nxt;
  // output
  logic [CH_W-1:0]            ch_out_r [N_LANES];
  logic [CH_W-1:0]            a_out_r;

  // Scale the weight by alpha: floor(q8 * w / 256).
  assign wprod  = $signed({1'b0, alpha_q8(alpha_in)}) * tap_weight;
  assign fw_nxt = mode_r ? wprod[WT_W+7:8] : tap_weight;

  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      cprod[i] = $signed({1'b0, s1_ch_r[i]}) * s1_fw_r;
    end
  end

  // Rounded numerators and magnitudes for the divider.
  always_comb begin
    tot_neg = tot_r[TOT_W-1];
    half    = (tot_r + $signed({{(TOT_W-1){1'b0}}, tot_neg})) >>> 1;
    abs_d   = tot_neg ? TOT_W'(-tot_r) : tot_r;
    for (int i = 0; i < N_LANES; i++) begin
      num[i]   = $signed({sum_r[i][SUM_W-1], sum_r[i]})
               + $signed({{(NUM_W-TOT_W){half[TOT_W-1]}}, half});
      abs_n[i] = num[i][NUM_W-1] ? NUM_W'(-num[i]) : num[i];
    end
    a255      = {tot_r, {CH_W{1'b0}}} - {{CH_W{tot_r[TOT_W-1]}}, tot_r};
    a_rnd     = a255 + DSH_W'(1 << (KQ - 1));
    a_hi      = a_rnd[DSH_W-1:KQ];
    alpha_sel = (a_hi > (DSH_W-KQ)'(255)) ? 8'hFF : a_hi[CH_W-1:0];
    empty_nxt = (tot_r == '0) || (fin_mode_r && tot_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      tot_r  <= '0;
      for (int i = 0; i < N_LANES; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      if (cmd.cfg_we) begin
        mode_r <= cfg_alpha_mode;
      end
      if (cmd.setup) begin
        tot_r <= '0;
        for (int i = 0; i < N_LANES; i++) begin
          sum_r[i] <= '0;
        end
      end else if (cmd.acc) begin
        tot_r <= tot_r + $signed({{(TOT_W-WT_W){s1_fw_r[WT_W-1]}}, s1_fw_r});
        for (int i = 0; i < N_LANES; i++) begin
          sum_r[i] <= sum_r[i]
                    + $signed({{(SUM_W-PROD_W){cprod[i][PROD_W-1]}}, cprod[i]});
        end
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1_ch_r[0] <= red_in;
      s1_ch_r[1] <= green_in;
      s1_ch_r[2] <= blue_in;
      s1_fw_r    <= fw_nxt;
      s1_mode_r  <= mode_r;
    end
    if (cmd.acc) begin
      fin_mode_r <= s1_mode_r;
    end
    if (cmd.setup) begin
      dsh_r   <= {abs_d, {CH_W{1'b0}}};
      empty_r <= empty_nxt;
      alpha_r <= fin_mode_r ? alpha_sel : 8'hFF;
      for (int i = 0; i < N_LANES; i++) begin
        rem_r[i] <= abs_n[i];
        quo_r[i] <= '0;
        neg_r[i] <= num[i][NUM_W-1] ^ tot_neg;
      end
    end else if (cmd.step) begin
      dsh_r <= dsh_r >> 1;
      for (int i = 0; i < N_LANES; i++) begin
        if (rem_r[i] >= {1'b0, dsh_r}) begin
          rem_r[i] <= rem_r[i] - {1'b0, dsh_r};
          quo_r[i] <= {quo_r[i][Q_W-2:0], 1'b1};
        end else begin
          quo_r[i] <= {quo_r[i][Q_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.finish) begin
      a_out_r <= empty_r ? '0 : alpha_r;
      for (int i = 0; i < N_LANES; i++) begin
        if (empty_r || neg_r[i]) begin
          ch_out_r[i] <= '0;
        end else if (quo_r[i][Q_W-1]) begin
          ch_out_r[i] <= 8'hFF;
        end else begin
          ch_out_r[i] <= quo_r[i][CH_W-1:0];
        end
      end
    end
  end

  assign red_out   = ch_out_r[0];
  assign green_out = ch_out_r[1];
  assign blue_out  = ch_out_r[2];
  assign alpha_out = a_out_r;

endmodule

`default_nettype wire

### sv/rgba_filter_tap_normalizer_core.sv
// ----------------------------------------------------------------------------
// rgba_filter_tap_normalizer_core - weighted RGBA tap sum with normalization
// Feed filter taps on the in_ stream; one normalized pixel leaves on the
// out_ stream per run of taps.
// Usage:
//   - Each in_ beat is one tap: RGBA pixel plus signed Q14 weight; in_tlast
//     closes the run. The MAX_TAPS-th tap since the last pixel closes it too.
//   - cfg_ selects opaque (0) or straight-alpha (1) weighting; write it only
//     while the block is idle. cfg_ready is always high.
//   - Taps within a run are taken one per cycle. After the closing tap the
//     block runs accumulate, operand setup, 9 divide steps and clamp, in that
//     order, before out_tvalid rises.
//   - in_tready is low from the closing tap until the pixel beat is taken.
//   - When out_tready is low the pixel beat holds on out_tdata unchanged.
//   - Reset (rst_n low, synchronous) clears the sums, tap count and mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_filter_tap_normalizer_core #(
  parameter int MAX_TAPS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tap stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [31:24] alpha_in,
  // [47:32] tap_weight
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tlast,   // last_tap
  // pixel stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] alpha_out
  output logic [31:0]      out_tdata,
  // mode register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // alpha_mode
);
  import rftn_pkg::*;

  cmd_t            cmd;
  logic [CH_W-1:0] red_out, green_out, blue_out, alpha_out;

  // Sequence taps, divide steps and the output beat.
  rftn_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd)
  );

  // Weight, accumulate, divide and clamp.
  rftn_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_alpha_mode (cfg_data),
    .red_in         (in_tdata[7:0]),
    .green_in       (in_tdata[15:8]),
    .blue_in        (in_tdata[23:16]),
    .alpha_in       (in_tdata[31:24]),
    .tap_weight     (in_tdata[47:32]),
    .red_out        (red_out),
    .green_out      (green_out),
    .blue_out       (blue_out),
    .alpha_out      (alpha_out)
  );

  assign out_tdata = {alpha_out, blue_out, green_out, red_out};

endmodule

`default_nettype wire

### dv/rgba_filter_tap_normalizer_core_test.sv
// ----------------------------------------------------------------------------
// rgba_filter_tap_normalizer_core_test - tap stream and pixel stream check
// Streams filter taps into the core and predicts every normalized pixel. A
// directed opening covers the boundary cases. Random runs of taps follow in
// both weighting modes, with random idle cycles on both streams and one long
// stall on the pixel side. Each pixel beat is compared field by field with
// the oldest predicted pixel.
// ----------------------------------------------------------------------------
module rgba_filter_tap_normalizer_core_test;
  import rftn_pkg::*;

  localparam int MAX_TAPS      = 8;
  localparam int PHASE_TAPS    = 150;  // random taps per mode setting
  localparam int N_PHASES      = 6;
  localparam int SETTLE_CYCLES = 20;   // covers the accumulate stage of a tap that closes nothing
  localparam int HOLD_CYCLES   = 300;  // long pixel-side stall

  typedef enum bit {MODE_OPAQUE = 1'b0, MODE_ALPHA = 1'b1} mode_t;

  typedef struct {
    logic [CH_W-1:0]        red;
    logic [CH_W-1:0]        green;
    logic [CH_W-1:0]        blue;
    logic [CH_W-1:0]        alpha;
    logic signed [WT_W-1:0] weight;
    logic                   last;
  } tap_t;

  // Same layout as out_tdata, red in the low byte.
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // Tracks the weighted sums of the open pixel and keeps predicted pixels in order.
  class pixel_scoreboard;
    mode_t  mode;
    longint sum_r, sum_g, sum_b, sum_w;
    int     taps;
    pixel_t pixels_due[$];
    int     errors;

    function new();
      mode   = MODE_OPAQUE;
      errors = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      sum_w = 0;
      taps  = 0;
    endfunction

    function logic [CH_W-1:0] clamp8(longint v);
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[CH_W-1:0];
    endfunction

    function void set_mode(mode_t m);
      mode = m;
    endfunction

    function int outstanding();
      return pixels_due.size();
    endfunction

    // Weight one tap; predict a pixel when the tap closes the run.
    function void note_tap(tap_t t);
      longint eff_w;
      longint total;
      longint half;
      pixel_t px;
      if (mode == MODE_ALPHA)
        eff_w = ((longint'(t.alpha) * 256 + 127) / 255 * longint'(t.weight)) >>> 8;
      else
        eff_w = longint'(t.weight);
      sum_r += longint'(t.red) * eff_w;
      sum_g += longint'(t.green) * eff_w;
      sum_b += longint'(t.blue) * eff_w;
      sum_w += eff_w;
      taps++;
      if (!t.last && taps < MAX_TAPS) return;
      total = sum_w;
      px    = '0;
      if ((mode == MODE_ALPHA && total > 0) || (mode == MODE_OPAQUE && total != 0)) begin
        half     = total / 2;
        px.red   = clamp8((sum_r + half) / total);
        px.green = clamp8((sum_g + half) / total);
        px.blue  = clamp8((sum_b + half) / total);
        if (mode == MODE_ALPHA)
          px.alpha = clamp8((total * 255 + (longint'(1) << (KQ - 1))) / (longint'(1) << KQ));
        else
          px.alpha = 8'd255;
      end
      pixels_due.push_back(px);
      clear_sums();
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      string  names[4];
      names = '{"red_out", "green_out", "blue_out", "alpha_out"};
      if (pixels_due.size() == 0) begin
        $display("%0t: pixel beat with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i*CH_W +: CH_W] !== want[i*CH_W +: CH_W]) begin
          $display("%0t: %s expected %0d actual %0d", $time, names[i],
                   want[i*CH_W +: CH_W], got[i*CH_W +: CH_W]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata  = '0;   // red, green, blue, alpha, tap_weight from bit 0 up
  logic        in_tlast  = 1'b0; // last_tap
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // red, green, blue, alpha from bit 0 up
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0; // alpha_mode

  bit tx_gaps   = 1'b1;
  bit rx_gaps   = 1'b1;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int taps_sent = 0;

  pixel_scoreboard sb = new();

  rgba_filter_tap_normalizer_core #(.MAX_TAPS(MAX_TAPS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one tap, idling first now and then; return once the beat is taken.
  // Leave tvalid high so back-to-back taps go out without an idle gap.
  task automatic send_tap(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic [7:0] a, input int w, input bit last);
    tap_t t;
    t.red    = r;
    t.green  = g;
    t.blue   = b;
    t.alpha  = a;
    t.weight = w[WT_W-1:0];
    t.last   = last;
    while (tx_gaps && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t.weight, a, b, g, r};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_tap(t);
    taps_sent++;
  endtask

  // Drop tvalid, wait out every predicted pixel, then let the accumulate
  // stage of a trailing open tap finish before touching the mode register.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  // One random run of taps. Most runs look like a resampling kernel: taps
  // whose weights add up near unity (Q14) with some negative lobes, closed by
  // tlast. The rest are runs that reach or pass the tap limit without tlast, and
  // noise with full-range weights and a random tlast.
  task automatic send_run();
    int         n;
    int         kind;
    int         w;
    bit         closing;
    logic [7:0] a;
    n    = $urandom_range(MAX_TAPS, 1);
    kind = $urandom_range(99);
    if (kind >= 75 && kind < 85) n = MAX_TAPS + $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      if (kind < 75)
        w = 16384 / n + $urandom_range(6000) - 3000;
      else
        w = $urandom_range(65535) - 32768;
      case ($urandom_range(9))
        0:       a = 8'h00;
        1, 2, 3: a = 8'hff;
        default: a = 8'($urandom_range(255));
      endcase
      if (kind < 75)
        closing = (i == n - 1);
      else if (kind < 85)
        closing = 1'b0;
      else
        closing = ($urandom_range(3) == 0);
      send_tap(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               a, w, closing);
    end
  endtask

  // Pixel side: check each taken beat, then choose tready for the next edge.
  // A hold request drops tready for a long stretch while taps keep coming.
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_pixel(out_tdata);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(rx_gaps && $urandom_range(99) < 6);
      end
    end
  end

  initial begin
    int start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opaque path.
    write_mode(MODE_OPAQUE);
    send_tap(8'd255, 8'd0, 8'd128, 8'd7, 16384, 1'b1);   // unity weight passes the pixel
    send_tap(8'd1, 8'd2, 8'd3, 8'd0, -32768, 1'b1);      // most negative weight, negative total
    send_tap(8'd200, 8'd100, 8'd50, 8'd0, 100, 1'b0);    // weights cancel: all-zero pixel
    send_tap(8'd10, 8'd20, 8'd30, 8'd0, -100, 1'b1);
    send_tap(8'd255, 8'd0, 8'd255, 8'd0, 20000, 1'b0);   // overshoot and undershoot clamp
    send_tap(8'd0, 8'd255, 8'd0, 8'd0, -4000, 1'b1);
    // Max weight on every tap, no tlast: the tap limit closes the pixel.
    for (int i = 0; i < MAX_TAPS; i++)
      send_tap(i[0] ? 8'hff : 8'h00, 8'hff, i[0] ? 8'h00 : 8'hff, 8'hff, 32767, 1'b0);

    // Switch the mode in the middle of a pixel.
    send_tap(8'd100, 8'd150, 8'd200, 8'd255, 8192, 1'b0);
    settle();
    write_mode(MODE_ALPHA);
    send_tap(8'd50, 8'd60, 8'd70, 8'd255, 8192, 1'b1);

    // Straight-alpha path.
    send_tap(8'd255, 8'd255, 8'd255, 8'd0, 16384, 1'b1);   // zero alpha: zero total
    send_tap(8'd90, 8'd180, 8'd30, 8'd255, 16384, 1'b1);   // full alpha, alpha_out 255
    send_tap(8'd255, 8'd255, 8'd255, 8'd128, -5, 1'b0);    // scaled weight rounds down
    send_tap(8'd40, 8'd80, 8'd120, 8'd200, 16000, 1'b1);
    send_tap(8'd10, 8'd10, 8'd10, 8'd255, -16384, 1'b1);   // negative total: all zero
    send_tap(8'd255, 8'd0, 8'd77, 8'd255, 32767, 1'b0);    // alpha_out clamps high
    send_tap(8'd0, 8'd255, 8'd77, 8'd255, 32767, 1'b0);
    send_tap(8'd128, 8'd128, 8'd77, 8'd255, 32767, 1'b1);
    settle();

    // Random runs; the second setting runs with no idling, the fourth
    // takes the long pixel-side stall.
    for (int p = 0; p < N_PHASES; p++) begin
      write_mode(mode_t'(p % 2));
      tx_gaps = (p != 1);
      rx_gaps = (p != 1);
      if (p == 3) hold_req = 1'b1;
      start = taps_sent;
      while (taps_sent - start < PHASE_TAPS) send_run();
      settle();
    end

    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
